FILE: hw/rtl/nine_slice_mesh_generator_top_assert.svh
// Assertion macros for the nine-slice mesh generator.
// Used by nine_slice_mesh_generator_top; no other dependencies.
`ifndef NINE_SLICE_MESH_GENERATOR_TOP_ASSERT_SVH
`define NINE_SLICE_MESH_GENERATOR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define NSM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nsm assertion failed");
`define NSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nsm assertion failed");
`else
`define NSM_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define NSM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/nsm_pkg.sv
// Shared types, constants and per-stage functions of the nine-slice mesh generator.
// No dependencies.
package nsm_pkg;

   localparam logic [16:0] ONE_Q16 = 17'h10000;
   localparam int DIV_BITS = 16;
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES = DIV_BITS / BITS_PER_STAGE;
   localparam int NSTG = DIV_STAGES + 1;

   typedef enum logic {PH_VERT, PH_TRI} phase_type;

   typedef struct packed {
      logic [16:0] s;
      logic [16:0] e;
      logic [17:0] sum;
      logic        dv;
      logic [16:0] rs;
      logic [16:0] re;
      logic [15:0] qs;
      logic [15:0] qe;
      logic [15:0] size;
      logic [15:0] corner;
   } axis_type;

   typedef struct packed {
      logic     quad;
      axis_type x;
      axis_type y;
   } item_type;

   typedef struct packed {
      logic             four;
      logic [3:0][15:0] pos;
      logic [3:0][16:0] uv;
   } pts_type;

   typedef struct packed {
      logic    quad;
      pts_type x;
      pts_type y;
   } mesh_type;

   // Clamp both cuts and form their sum; the remainders start at the cuts.
   function automatic axis_type axis_init(logic [16:0] ca, logic [16:0] cb,
                                          logic [15:0] size, logic [15:0] corner);
      axis_type a;
      a.s = (ca > ONE_Q16) ? ONE_Q16 : ca;
      a.e = (cb > ONE_Q16) ? ONE_Q16 : cb;
      a.sum = {1'b0, a.s} + {1'b0, a.e};
      a.dv = (a.sum > {1'b0, ONE_Q16});
      a.rs = a.s;
      a.re = a.e;
      a.qs = '0;
      a.qe = '0;
      a.size = size;
      a.corner = corner;
      return a;
   endfunction

   // One restoring division step: {quotient bit, new remainder}.
   function automatic logic [17:0] rstep(logic [16:0] r, logic [17:0] d);
      logic [17:0] r2;
      logic [17:0] df;
      r2 = {r, 1'b0};
      df = r2 - d;
      if (r2 >= d) begin
         return {1'b1, df[16:0]};
      end
      return {1'b0, r2[16:0]};
   endfunction

   // Advance both divisions of one axis by a stage's worth of bits.
   function automatic axis_type axis_div(axis_type ai);
      axis_type    a;
      logic [17:0] t;
      a = ai;
      for (int i = 0; i < BITS_PER_STAGE; i++) begin
         t = rstep(a.rs, a.sum);
         a.rs = t[16:0];
         a.qs = {a.qs[14:0], t[17]};
         t = rstep(a.re, a.sum);
         a.re = t[16:0];
         a.qe = {a.qe[14:0], t[17]};
      end
      return a;
   endfunction

   // Work out the slice points of one axis.
   function automatic pts_type axis_pts(axis_type a);
      pts_type     p;
      logic [16:0] su;
      logic [16:0] eu;
      logic [16:0] ef;
      logic [15:0] c;
      logic [15:0] half;
      su = a.dv ? {1'b0, a.qs} : a.s;
      ef = a.dv ? {1'b0, a.qe} : a.e;
      eu = ONE_Q16 - ef;
      half = {1'b0, a.size[15:1]};
      c = (a.corner > half) ? half : a.corner;
      p.four = (a.corner != '0) && (eu > su) && !((su == '0) && (eu == ONE_Q16));
      if (p.four) begin
         p.pos = {a.size, 16'(a.size - c), c, 16'd0};
         p.uv = {ONE_Q16, eu, su, 17'd0};
      end else begin
         p.pos = {16'd0, 16'd0, a.size, 16'd0};
         p.uv = {17'd0, 17'd0, ONE_Q16, 17'd0};
      end
      return p;
   endfunction

endpackage

FILE: hw/rtl/nsm_expand.sv
// Result emitter: walks one mesh's vertices and triangles, one transfer a cycle while rsp_ready allows.
// Depends on nsm_pkg.
module nsm_expand (
   input  logic              clock,
   input  logic              reset,
   input  logic              mesh_valid,
   input  nsm_pkg::mesh_type mesh,
   output logic              mesh_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic [15:0]       rsp_pos_x,
   output logic [15:0]       rsp_pos_y,
   output logic [16:0]       rsp_tex_u,
   output logic [16:0]       rsp_tex_v,
   output logic [3:0]        rsp_index_a,
   output logic [3:0]        rsp_index_b,
   output logic [3:0]        rsp_index_c,
   output logic              rsp_last
);

   nsm_pkg::mesh_type  mesh_ff;
   logic               busy_ff, busy_in;
   nsm_pkg::phase_type phase_ff, phase_in;
   logic [1:0]         row_ff, row_in, col_ff, col_in;
   logic               half_ff, half_in;
   logic               valid_ff;
   logic               kind_ff, kind_in, last_ff, last_in;
   logic [15:0]        px_ff, px_in, py_ff, py_in;
   logic [16:0]        tu_ff, tu_in, tv_ff, tv_in;
   logic [3:0]         ia_ff, ia_in, ib_ff, ib_in, ic_ff, ic_in;
   logic               out_en, done;
   logic [1:0]         nc, nr, ce;
   logic [3:0]         b, cols;

   assign out_en = !valid_ff || rsp_ready;
   assign nc = mesh_ff.x.four ? 2'd3 : 2'd1;
   assign nr = mesh_ff.y.four ? 2'd3 : 2'd1;
   assign cols = mesh_ff.x.four ? 4'd4 : 4'd2;
   assign done = (phase_ff == nsm_pkg::PH_TRI) && half_ff && (row_ff == nr - 2'd1)
                 && (col_ff == nc - 2'd1);
   assign mesh_ready = !busy_ff || (out_en && done);

   // Advance the walk counters
   always_comb begin
      busy_in = busy_ff;
      phase_in = phase_ff;
      row_in = row_ff;
      col_in = col_ff;
      half_in = half_ff;
      if (busy_ff && out_en) begin
         if (phase_ff == nsm_pkg::PH_VERT) begin
            if (col_ff == nc) begin
               col_in = 2'd0;
               if (row_ff == nr) begin
                  row_in = 2'd0;
                  half_in = 1'b0;
                  phase_in = nsm_pkg::PH_TRI;
               end else begin
                  row_in = row_ff + 2'd1;
               end
            end else begin
               col_in = col_ff + 2'd1;
            end
         end else begin
            half_in = !half_ff;
            if (half_ff) begin
               if (col_ff == nc - 2'd1) begin
                  col_in = 2'd0;
                  row_in = row_ff + 2'd1;
               end else begin
                  col_in = col_ff + 2'd1;
               end
               if (done) begin
                  busy_in = 1'b0;
               end
            end
         end
      end
      if (mesh_valid && mesh_ready) begin
         busy_in = 1'b1;
         phase_in = nsm_pkg::PH_VERT;
         row_in = 2'd0;
         col_in = 2'd0;
         half_in = 1'b0;
      end
   end

   // Form the next result item
   always_comb begin
      // the single quad walks its top row right to left
      ce = (mesh_ff.quad && row_ff[0]) ? {col_ff[1], ~col_ff[0]} : col_ff;
      b = mesh_ff.x.four ? {row_ff, col_ff} : {1'b0, row_ff, col_ff[0]};
      kind_in = (phase_ff == nsm_pkg::PH_TRI);
      last_in = done;
      px_in = '0;
      py_in = '0;
      tu_in = '0;
      tv_in = '0;
      ia_in = '0;
      ib_in = '0;
      ic_in = '0;
      if (phase_ff == nsm_pkg::PH_VERT) begin
         px_in = mesh_ff.x.pos[ce];
         py_in = mesh_ff.y.pos[row_ff];
         tu_in = mesh_ff.x.uv[ce];
         tv_in = mesh_ff.y.uv[row_ff];
      end else if (mesh_ff.quad) begin
         ib_in = half_ff ? 4'd2 : 4'd1;
         ic_in = half_ff ? 4'd3 : 4'd2;
      end else begin
         ia_in = b;
         ib_in = half_ff ? b + cols + 4'd1 : b + 4'd1;
         ic_in = half_ff ? b + cols : b + cols + 4'd1;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         valid_ff <= 1'b0;
         phase_ff <= nsm_pkg::PH_VERT;
         row_ff <= '0;
         col_ff <= '0;
         half_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         phase_ff <= phase_in;
         row_ff <= row_in;
         col_ff <= col_in;
         half_ff <= half_in;
         if (out_en) begin
            valid_ff <= busy_ff;
         end
      end
   end

   // Load mesh and output payload
   always_ff @(posedge clock) begin
      if (mesh_valid && mesh_ready) begin
         mesh_ff <= mesh;
      end
      if (out_en && busy_ff) begin
         kind_ff <= kind_in;
         last_ff <= last_in;
         px_ff <= px_in;
         py_ff <= py_in;
         tu_ff <= tu_in;
         tv_ff <= tv_in;
         ia_ff <= ia_in;
         ib_ff <= ib_in;
         ic_ff <= ic_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_kind = kind_ff;
   assign rsp_pos_x = px_ff;
   assign rsp_pos_y = py_ff;
   assign rsp_tex_u = tu_ff;
   assign rsp_tex_v = tv_ff;
   assign rsp_index_a = ia_ff;
   assign rsp_index_b = ib_ff;
   assign rsp_index_c = ic_ff;
   assign rsp_last = last_ff;

endmodule

FILE: hw/rtl/nine_slice_mesh_generator_top.sv
// Nine-slice mesh generator: a request, accepted each cycle while the pipeline is not stalled,
// results in up to 34 result transfers, one per cycle while rsp_ready allows. A request passes
// an input stage, eight divider stages (two quotient bits each, both cuts of both axes in
// parallel) and a slice point stage, then the emitter walks the mesh: 6 transfers for a single
// quad and columns*rows + 2*(columns-1)*(rows-1) transfers otherwise (6 to 34). The emitter
// sets the sustained rate; the pipeline stalls as a whole when it is busy.
// Depends on nsm_pkg, nsm_expand and nine_slice_mesh_generator_top_assert.svh.
`include "nine_slice_mesh_generator_top_assert.svh"
module nine_slice_mesh_generator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_size_x,
   input  logic [15:0] req_size_y,
   input  logic [16:0] req_cut_left,
   input  logic [16:0] req_cut_right,
   input  logic [16:0] req_cut_bottom,
   input  logic [16:0] req_cut_top,
   input  logic [15:0] req_corner_x,
   input  logic [15:0] req_corner_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [15:0] rsp_pos_x,
   output logic [15:0] rsp_pos_y,
   output logic [16:0] rsp_tex_u,
   output logic [16:0] rsp_tex_v,
   output logic [3:0]  rsp_index_a,
   output logic [3:0]  rsp_index_b,
   output logic [3:0]  rsp_index_c,
   output logic        rsp_last
);

   nsm_pkg::item_type             stg_ff [nsm_pkg::NSTG];
   logic [nsm_pkg::NSTG-1:0]      vld_ff;
   nsm_pkg::mesh_type             mesh_ff, mesh_in;
   logic                          mesh_vld_ff;
   logic                          mesh_ready;
   logic                          en;
   nsm_pkg::item_type             first_in;

   assign en = !mesh_vld_ff || mesh_ready;
   assign req_ready = en;

   // Clamp cuts and form sums at entry
   always_comb begin
      first_in.quad = (req_cut_left == '0) && (req_cut_right == '0) &&
                      (req_cut_bottom == '0) && (req_cut_top == '0);
      first_in.x = nsm_pkg::axis_init(req_cut_left, req_cut_right, req_size_x,
                                      req_corner_x);
      first_in.y = nsm_pkg::axis_init(req_cut_bottom, req_cut_top, req_size_y,
                                      req_corner_y);
   end

   // Work out slice points after the last divider stage
   always_comb begin
      mesh_in.quad = stg_ff[nsm_pkg::NSTG-1].quad;
      mesh_in.x = nsm_pkg::axis_pts(stg_ff[nsm_pkg::NSTG-1].x);
      mesh_in.y = nsm_pkg::axis_pts(stg_ff[nsm_pkg::NSTG-1].y);
   end

   // Advance valid bits as one pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         mesh_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= {vld_ff[nsm_pkg::NSTG-2:0], req_valid};
         mesh_vld_ff <= vld_ff[nsm_pkg::NSTG-1];
      end
   end

   // Advance payload: entry, divider stages, slice points
   always_ff @(posedge clock) begin
      if (en) begin
         stg_ff[0] <= first_in;
         for (int i = 1; i < nsm_pkg::NSTG; i++) begin
            stg_ff[i].quad <= stg_ff[i-1].quad;
            stg_ff[i].x <= nsm_pkg::axis_div(stg_ff[i-1].x);
            stg_ff[i].y <= nsm_pkg::axis_div(stg_ff[i-1].y);
         end
         mesh_ff <= mesh_in;
      end
   end

   nsm_expand u_expand (
      .clock       (clock),
      .reset       (reset),
      .mesh_valid  (mesh_vld_ff),
      .mesh        (mesh_ff),
      .mesh_ready  (mesh_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_kind    (rsp_kind),
      .rsp_pos_x   (rsp_pos_x),
      .rsp_pos_y   (rsp_pos_y),
      .rsp_tex_u   (rsp_tex_u),
      .rsp_tex_v   (rsp_tex_v),
      .rsp_index_a (rsp_index_a),
      .rsp_index_b (rsp_index_b),
      .rsp_index_c (rsp_index_c),
      .rsp_last    (rsp_last)
   );

   `NSM_ASSERT_IMPLY(a_last_is_tri, clock, reset, rsp_valid && rsp_last, rsp_kind)
   `NSM_ASSERT_IMPLY(a_tri_no_pos, clock, reset, rsp_valid && rsp_kind, (rsp_pos_x == '0) && (rsp_tex_u == '0))
   `NSM_ASSERT_IMPLY(a_vert_no_idx, clock, reset, rsp_valid && !rsp_kind, (rsp_index_a == '0) && (rsp_index_c == '0))

endmodule

FILE: test/testbench.sv
// Self-checking testbench for nine_slice_mesh_generator_top.
// Drives mesh requests, predicts every vertex and triangle transfer, and
// compares them in order. Depends on nsm_pkg and the block's RTL.
`timescale 1ns / 1ps
module testbench;

   // Expected transfer on the result channel
   typedef struct packed {
      logic        kind;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [16:0] tex_u;
      logic [16:0] tex_v;
      logic [3:0]  index_a;
      logic [3:0]  index_b;
      logic [3:0]  index_c;
      logic        last;
   } mesh_item_t;

   // One request
   typedef struct packed {
      logic [15:0] size_x;
      logic [15:0] size_y;
      logic [16:0] cut_left;
      logic [16:0] cut_right;
      logic [16:0] cut_bottom;
      logic [16:0] cut_top;
      logic [15:0] corner_x;
      logic [15:0] corner_y;
   } sprite_req_t;

   localparam logic KIND_VERTEX   = 1'b0;
   localparam logic KIND_TRIANGLE = 1'b1;
   localparam logic [16:0] UV_ONE = nsm_pkg::ONE_Q16;
   localparam int MAX_WAIT = 17;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [15:0] req_size_x;
   logic [15:0] req_size_y;
   logic [16:0] req_cut_left;
   logic [16:0] req_cut_right;
   logic [16:0] req_cut_bottom;
   logic [16:0] req_cut_top;
   logic [15:0] req_corner_x;
   logic [15:0] req_corner_y;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_kind;
   logic [15:0] rsp_pos_x;
   logic [15:0] rsp_pos_y;
   logic [16:0] rsp_tex_u;
   logic [16:0] rsp_tex_v;
   logic [3:0]  rsp_index_a;
   logic [3:0]  rsp_index_b;
   logic [3:0]  rsp_index_c;
   logic        rsp_last;

   mesh_item_t  mesh_queue[$];
   int          mismatch_count = 0;
   int          long_hold = 0;
   bit          stim_done = 0;

   nine_slice_mesh_generator_top u_dut (.*);

   // 4 ns clock
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Slice points of one axis; returns the number of points
   function automatic int slice_axis(input logic [16:0] cut_a, input logic [16:0] cut_b,
                                     input logic [15:0] size, input logic [15:0] corner,
                                     output logic [15:0] pos[4], output logic [16:0] uv[4]);
      logic [63:0] s;
      logic [63:0] e;
      logic [63:0] sum;
      logic [63:0] su;
      logic [63:0] eu;
      logic [15:0] c;
      s = (cut_a > UV_ONE) ? 64'(UV_ONE) : 64'(cut_a);
      e = (cut_b > UV_ONE) ? 64'(UV_ONE) : 64'(cut_b);
      sum = s + e;
      if (sum > UV_ONE) begin
         s = (s * 64'd65536) / sum;
         e = (e * 64'd65536) / sum;
      end
      su = s;
      eu = 64'd65536 - e;
      pos[0] = 16'd0;
      uv[0] = 17'd0;
      if (corner == 16'd0 || eu <= su || (su == 0 && eu >= 65536)) begin
         pos[1] = size;
         uv[1] = UV_ONE;
         return 2;
      end
      c = (corner > (size >> 1)) ? (size >> 1) : corner;
      pos[1] = c;
      uv[1] = su[16:0];
      pos[2] = size - c;
      uv[2] = eu[16:0];
      pos[3] = size;
      uv[3] = UV_ONE;
      return 4;
   endfunction

   function automatic mesh_item_t vertex(logic [15:0] x, logic [15:0] y,
                                         logic [16:0] u, logic [16:0] v);
      mesh_item_t m;
      m = '0;
      m.kind = KIND_VERTEX;
      m.pos_x = x;
      m.pos_y = y;
      m.tex_u = u;
      m.tex_v = v;
      return m;
   endfunction

   function automatic mesh_item_t triangle(int a, int b, int c);
      mesh_item_t m;
      m = '0;
      m.kind = KIND_TRIANGLE;
      m.index_a = a[3:0];
      m.index_b = b[3:0];
      m.index_c = c[3:0];
      return m;
   endfunction

   // Add one expected transfer at the tail of the queue
   function automatic void append_want(input mesh_item_t m);
      mesh_queue.insert(mesh_queue.size(), m);
   endfunction

   // Append the whole mesh of one request to the expected queue
   task automatic build_mesh(input sprite_req_t r);
      logic [15:0] px[4];
      logic [15:0] py[4];
      logic [16:0] ux[4];
      logic [16:0] uy[4];
      int cols;
      int rows;
      int b;
      mesh_item_t m;
      if (r.cut_left == 0 && r.cut_right == 0 && r.cut_bottom == 0 && r.cut_top == 0) begin
         append_want(vertex(16'd0, 16'd0, 17'd0, 17'd0));
         append_want(vertex(r.size_x, 16'd0, UV_ONE, 17'd0));
         append_want(vertex(r.size_x, r.size_y, UV_ONE, UV_ONE));
         append_want(vertex(16'd0, r.size_y, 17'd0, UV_ONE));
         append_want(triangle(0, 1, 2));
         m = triangle(0, 2, 3);
         m.last = 1'b1;
         append_want(m);
         return;
      end
      cols = slice_axis(r.cut_left, r.cut_right, r.size_x, r.corner_x, px, ux);
      rows = slice_axis(r.cut_bottom, r.cut_top, r.size_y, r.corner_y, py, uy);
      for (int row = 0; row < rows; row++)
         for (int col = 0; col < cols; col++)
            append_want(vertex(px[col], py[row], ux[col], uy[row]));
      for (int row = 0; row + 1 < rows; row++)
         for (int col = 0; col + 1 < cols; col++) begin
            b = row * cols + col;
            append_want(triangle(b, b + 1, b + cols + 1));
            append_want(triangle(b, b + cols + 1, b + cols));
         end
      mesh_queue[mesh_queue.size() - 1].last = 1'b1;
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Random request: mostly sliced meshes with random content
   function automatic sprite_req_t random_req();
      sprite_req_t r;
      int mode;
      r.size_x = 16'($urandom);
      r.size_y = 16'($urandom);
      r.corner_x = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
      r.corner_y = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
      if ($urandom_range(0, 3) == 0) begin
         r.corner_x = 16'($urandom_range(0, 255));
         r.corner_y = 16'($urandom_range(0, 255));
      end
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
         r.cut_left = '0; r.cut_right = '0; r.cut_bottom = '0; r.cut_top = '0;
      end else if (mode <= 2) begin
         // full range, including clamping and big sums
         r.cut_left = 17'($urandom); r.cut_right = 17'($urandom);
         r.cut_bottom = 17'($urandom); r.cut_top = 17'($urandom);
      end else begin
         r.cut_left = 17'($urandom_range(0, 40000));
         r.cut_right = 17'($urandom_range(0, 40000));
         r.cut_bottom = 17'($urandom_range(0, 40000));
         r.cut_top = 17'($urandom_range(0, 40000));
         if ($urandom_range(0, 5) == 0) r.cut_left = '0;
         if ($urandom_range(0, 5) == 0) r.cut_top = '0;
      end
      return r;
   endfunction

   // Offer one request and hold it until the transfer
   task automatic send_req(input sprite_req_t r);
      req_valid <= 1'b1;
      req_size_x <= r.size_x;
      req_size_y <= r.size_y;
      req_cut_left <= r.cut_left;
      req_cut_right <= r.cut_right;
      req_cut_bottom <= r.cut_bottom;
      req_cut_top <= r.cut_top;
      req_corner_x <= r.corner_x;
      req_corner_y <= r.corner_y;
      do @(posedge clock); while (!req_ready);
      build_mesh(r);
   endtask

   task automatic send_with_gap(input sprite_req_t r);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      send_req(r);
   endtask

   // Stimulus
   initial begin
      sprite_req_t dir_table [12];
      sprite_req_t r;
      mesh_item_t want;
      reset = 1'b1;
      req_valid = 1'b0;
      {req_size_x, req_size_y, req_cut_left, req_cut_right} = '0;
      {req_cut_bottom, req_cut_top, req_corner_x, req_corner_y} = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows: quad, extremes, clamp, sum above one, unsliced axes
      dir_table[0] = '{16'h0000, 16'h0000, 17'h00000, 17'h00000, 17'h00000, 17'h00000,
                       16'h0000, 16'h0000};
      dir_table[1] = '{16'hFFFF, 16'hFFFF, 17'h00000, 17'h00000, 17'h00000, 17'h00000,
                       16'hFFFF, 16'hFFFF};
      dir_table[2] = '{16'h0640, 16'h0320, 17'h04000, 17'h04000, 17'h04000, 17'h04000,
                       16'h0080, 16'h0080};
      dir_table[3] = '{16'hFFFF, 16'hFFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF,
                       16'hFFFF, 16'hFFFF};
      dir_table[4] = '{16'h1000, 16'h1000, 17'h0C000, 17'h08000, 17'h18000, 17'h00001,
                       16'h0100, 16'h0100};
      dir_table[5] = '{16'h1000, 16'h1000, 17'h04000, 17'h04000, 17'h04000, 17'h04000,
                       16'h0000, 16'h0000};
      dir_table[6] = '{16'h1000, 16'h1000, 17'h10000, 17'h00000, 17'h00000, 17'h10000,
                       16'h0100, 16'h0100};
      dir_table[7] = '{16'h0001, 16'h0001, 17'h00001, 17'h00000, 17'h00000, 17'h00001,
                       16'hFFFF, 16'hFFFF};
      dir_table[8] = '{16'h2000, 16'h0800, 17'h00000, 17'h00001, 17'h00001, 17'h00000,
                       16'h0001, 16'h0001};
      dir_table[9] = '{16'h2000, 16'h0800, 17'h08000, 17'h08000, 17'h0FFFF, 17'h00001,
                       16'h0400, 16'h0400};
      dir_table[10] = '{16'h3000, 16'h3000, 17'h04000, 17'h04000, 17'h00000, 17'h00000,
                        16'h0100, 16'h0100};
      dir_table[11] = '{16'h0000, 16'h0000, 17'h00000, 17'h00000, 17'h00000, 17'h00001,
                        16'h0000, 16'h0010};
      foreach (dir_table[i]) begin
         send_with_gap(dir_table[i]);
         // the second, full-size quad can be read off directly
         if (i == 1) begin
            want = mesh_queue[mesh_queue.size() - 4];
            if (want.pos_x != 16'hFFFF || want.tex_u != UV_ONE)
               report("quad table", want.pos_x, 16'hFFFF);
         end
      end

      // Random requests
      for (int n = 0; n < 250; n++) begin
         if (n == 60) long_hold = 400;
         if (n == 150) begin
            // pause until all results have drained
            req_valid <= 1'b0;
            while (mesh_queue.size() != 0) @(posedge clock);
         end
         r = random_req();
         send_with_gap(r);
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // Receiver: random stalls plus one long hold
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         if (long_hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (long_hold) @(posedge clock);
            long_hold = 0;
         end
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      mesh_item_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (mesh_queue.size() == 0) begin
            report("unexpected transfer", rsp_kind, 0);
         end else begin
            want = mesh_queue.pop_front();
            if (rsp_kind !== want.kind) report("kind", rsp_kind, want.kind);
            if (rsp_pos_x !== want.pos_x) report("pos_x", rsp_pos_x, want.pos_x);
            if (rsp_pos_y !== want.pos_y) report("pos_y", rsp_pos_y, want.pos_y);
            if (rsp_tex_u !== want.tex_u) report("tex_u", rsp_tex_u, want.tex_u);
            if (rsp_tex_v !== want.tex_v) report("tex_v", rsp_tex_v, want.tex_v);
            if (rsp_index_a !== want.index_a) report("index_a", rsp_index_a, want.index_a);
            if (rsp_index_b !== want.index_b) report("index_b", rsp_index_b, want.index_b);
            if (rsp_index_c !== want.index_c) report("index_c", rsp_index_c, want.index_c);
            if (rsp_last !== want.last) report("last", rsp_last, want.last);
         end
      end
   end

   // End of run
   initial begin
      wait (stim_done);
      while (mesh_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Limit on run time
   initial begin
      #5000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
